// File: sv/vpf_pkg.sv
package vpf_pkg;

   localparam int VPF_COORD_W        = 16;
   localparam int VPF_CTRL_W         = 18;
   localparam int VPF_CURVE_SEGMENTS = 12;
   localparam int VPF_QUEUE_DEPTH    = 2;

   localparam logic signed [VPF_COORD_W-1:0] VPF_COORD_MAX = 16'sh7FFF;
   localparam logic signed [VPF_COORD_W-1:0] VPF_COORD_MIN = 16'sh8000;

   localparam logic [1:0] VPF_KIND_FIRST = 2'd0;
   localparam logic [1:0] VPF_KIND_NEXT  = 2'd1;
   localparam logic [1:0] VPF_KIND_CLOSE = 2'd2;

   typedef enum logic [2:0] {
      VPF_CMD_MOVE,
      VPF_CMD_LINE,
      VPF_CMD_HORIZ,
      VPF_CMD_VERT,
      VPF_CMD_CUBIC,
      VPF_CMD_SMOOTH,
      VPF_CMD_CLOSE,
      VPF_CMD_END
   } vpf_cmd_type;

   typedef enum logic {
      VPF_JOB_POINT,
      VPF_JOB_CURVE
   } vpf_op_type;

   typedef enum logic [1:0] {
      VPF_BK_IDLE,
      VPF_BK_LEAD,
      VPF_BK_STEP
   } vpf_back_state_type;

   typedef struct packed {
      logic [2:0]                    command;
      logic                          relative;
      logic signed [VPF_COORD_W-1:0] ctrl1_x;
      logic signed [VPF_COORD_W-1:0] ctrl1_y;
      logic signed [VPF_COORD_W-1:0] ctrl2_x;
      logic signed [VPF_COORD_W-1:0] ctrl2_y;
      logic signed [VPF_COORD_W-1:0] end_x;
      logic signed [VPF_COORD_W-1:0] end_y;
   } vpf_req_type;

   typedef struct packed {
      logic signed [VPF_COORD_W-1:0] point_x;
      logic signed [VPF_COORD_W-1:0] point_y;
      logic [1:0]                    point_kind;
      logic                          last;
   } vpf_rsp_type;

   typedef struct packed {
      logic signed [VPF_COORD_W-1:0] x;
      logic signed [VPF_COORD_W-1:0] y;
   } vpf_point_type;

   // One unit of work for the back end: a single point or a whole cubic,
   // optionally preceded by the held first point of the subpath.
   typedef struct packed {
      vpf_op_type                   op;
      logic                         lead;
      logic [1:0]                   kind;
      vpf_point_type                lead_pt;
      vpf_point_type                p0;
      logic signed [VPF_CTRL_W-1:0] c1_x;
      logic signed [VPF_CTRL_W-1:0] c1_y;
      logic signed [VPF_CTRL_W-1:0] c2_x;
      logic signed [VPF_CTRL_W-1:0] c2_y;
      vpf_point_type                p3;
   } vpf_job_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       last;
   } vpf_meta_type;

   // Bernstein weights never exceed segments cubed.
   function automatic int vpf_wgt_width(int segments);
      return $clog2(segments * segments * segments + 1);
   endfunction

endpackage

// File: sv/vpf_front.sv
module vpf_front
   import vpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  vpf_req_type req_data,
   input  logic        q_full,
   output logic        push,
   output vpf_job_type push_data
);

   function automatic logic signed [VPF_CTRL_W-1:0] sext(input logic signed [VPF_COORD_W-1:0] v);
      return {{(VPF_CTRL_W-VPF_COORD_W){v[VPF_COORD_W-1]}}, v};
   endfunction

   function automatic logic signed [VPF_COORD_W-1:0] sat(input logic signed [VPF_CTRL_W-1:0] v);
      logic signed [VPF_COORD_W-1:0] r;
      if (v > sext(VPF_COORD_MAX)) begin
         r = VPF_COORD_MAX;
      end else if (v < sext(VPF_COORD_MIN)) begin
         r = VPF_COORD_MIN;
      end else begin
         r = v[VPF_COORD_W-1:0];
      end
      return r;
   endfunction

   vpf_point_type cur_ff, cur_in;
   vpf_point_type start_ff, start_in;
   vpf_point_type lastc_ff, lastc_in;
   vpf_point_type held_ff, held_in;
   logic          held_valid_ff, held_valid_in;
   logic          emitted_ff, emitted_in;

   logic                         accept;
   logic                         open_sub;
   vpf_point_type                base;
   vpf_point_type                tgt;
   vpf_point_type                lead_pt;
   vpf_point_type                start_d;
   logic signed [VPF_CTRL_W-1:0] c1_x, c1_y, c2_x, c2_y;
   logic signed [VPF_CTRL_W-1:0] sm_x, sm_y;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign base  = req_data.relative ? cur_ff : '0;
   assign c1_x  = sext(req_data.ctrl1_x) + sext(base.x);
   assign c1_y  = sext(req_data.ctrl1_y) + sext(base.y);
   assign c2_x  = sext(req_data.ctrl2_x) + sext(base.x);
   assign c2_y  = sext(req_data.ctrl2_y) + sext(base.y);
   assign tgt.x = sat(sext(req_data.end_x) + sext(base.x));
   assign tgt.y = sat(sext(req_data.end_y) + sext(base.y));

   // reflect the previous control point about the current point
   assign sm_x = {cur_ff.x[VPF_COORD_W-1], cur_ff.x, 1'b0} - sext(lastc_ff.x);
   assign sm_y = {cur_ff.y[VPF_COORD_W-1], cur_ff.y, 1'b0} - sext(lastc_ff.y);

   // drawing with no open subpath starts one at the current point
   assign open_sub = !held_valid_ff && !emitted_ff;
   assign lead_pt  = held_valid_ff ? held_ff : cur_ff;
   assign start_d  = open_sub ? cur_ff : start_ff;

   always_comb begin
      cur_in        = cur_ff;
      start_in      = start_ff;
      lastc_in      = lastc_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      emitted_in    = emitted_ff;
      push          = 1'b0;
      push_data     = '0;
      push_data.lead    = !emitted_ff;
      push_data.lead_pt = lead_pt;
      push_data.kind    = VPF_KIND_NEXT;
      if (accept) begin
         case (req_data.command)
            VPF_CMD_MOVE: begin
               cur_in        = tgt;
               start_in      = tgt;
               held_in       = tgt;
               lastc_in      = tgt;
               held_valid_in = 1'b1;
               emitted_in    = 1'b0;
            end
            VPF_CMD_LINE, VPF_CMD_HORIZ, VPF_CMD_VERT: begin
               push         = 1'b1;
               push_data.op = VPF_JOB_POINT;
               push_data.p0 = tgt;
               if (req_data.command == VPF_CMD_HORIZ) begin
                  push_data.p0.y = cur_ff.y;
               end
               if (req_data.command == VPF_CMD_VERT) begin
                  push_data.p0.x = cur_ff.x;
               end
               if (open_sub) begin
                  held_in = cur_ff;
               end
               start_in      = start_d;
               cur_in        = push_data.p0;
               lastc_in      = push_data.p0;
               held_valid_in = 1'b0;
               emitted_in    = 1'b1;
            end
            VPF_CMD_CUBIC, VPF_CMD_SMOOTH: begin
               push           = 1'b1;
               push_data.op   = VPF_JOB_CURVE;
               push_data.p0   = cur_ff;
               push_data.c1_x = (req_data.command == VPF_CMD_SMOOTH) ? sm_x : c1_x;
               push_data.c1_y = (req_data.command == VPF_CMD_SMOOTH) ? sm_y : c1_y;
               push_data.c2_x = c2_x;
               push_data.c2_y = c2_y;
               push_data.p3   = tgt;
               if (open_sub) begin
                  held_in = cur_ff;
               end
               start_in      = start_d;
               cur_in        = tgt;
               lastc_in.x    = sat(c2_x);
               lastc_in.y    = sat(c2_y);
               held_valid_in = 1'b0;
               emitted_in    = 1'b1;
            end
            VPF_CMD_CLOSE: begin
               push           = emitted_ff;
               push_data.op   = VPF_JOB_POINT;
               push_data.lead = 1'b0;
               push_data.kind = VPF_KIND_CLOSE;
               push_data.p0   = start_ff;
               cur_in         = start_ff;
               lastc_in       = start_ff;
               held_valid_in  = 1'b0;
               emitted_in     = 1'b0;
            end
            default: begin
               cur_in        = '0;
               start_in      = '0;
               lastc_in      = '0;
               held_in       = '0;
               held_valid_in = 1'b0;
               emitted_in    = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= '0;
         start_ff      <= '0;
         lastc_ff      <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         emitted_ff    <= 1'b0;
      end else begin
         cur_ff        <= cur_in;
         start_ff      <= start_in;
         lastc_ff      <= lastc_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         emitted_ff    <= emitted_in;
      end
   end

endmodule

// File: sv/vpf_queue.sv
module vpf_queue
   import vpf_pkg::*;
#(
   parameter int DEPTH = VPF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  vpf_job_type push_data,
   output logic        full,
   input  logic        pop,
   output vpf_job_type pop_data,
   output logic        empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   vpf_job_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("queue fill count lost a word");
`endif

endmodule

// File: sv/vpf_eval.sv
module vpf_eval
   import vpf_pkg::*;
#(
   parameter int SEGMENTS = VPF_CURVE_SEGMENTS
) (
   input  logic                                   clock,
   input  logic                                   enable,
   input  logic [3:0][vpf_wgt_width(SEGMENTS)-1:0] wgt,
   input  logic signed [VPF_COORD_W-1:0]          p0,
   input  logic signed [VPF_CTRL_W-1:0]           p1,
   input  logic signed [VPF_CTRL_W-1:0]           p2,
   input  logic signed [VPF_COORD_W-1:0]          p3,
   output logic signed [VPF_COORD_W-1:0]          point
);

   localparam int     WGT_W  = vpf_wgt_width(SEGMENTS);
   localparam int     CUBE   = SEGMENTS * SEGMENTS * SEGMENTS;
   localparam int     DEN2   = 2 * CUBE;
   localparam int     PRD_W  = VPF_CTRL_W + WGT_W + 1;
   localparam int     X_W    = PRD_W + 4;
   localparam int     D2_W   = $clog2(DEN2 + 1);
   localparam int     Z_W    = VPF_COORD_W + D2_W;
   localparam int     M_W    = Z_W - $clog2(DEN2) + 2;
   localparam longint RECIP  = (longint'(1) << Z_W) / DEN2;
   localparam longint OFFSET = longint'(DEN2) << (VPF_COORD_W - 1);

   localparam logic signed [X_W-1:0] OFF_X     = X_W'(OFFSET);
   localparam logic signed [X_W-1:0] NEG_OFF_X = -OFF_X;
   localparam logic signed [X_W-1:0] CUBE_X    = X_W'(CUBE);
   localparam logic [M_W-1:0]        RECIP_M   = M_W'(RECIP);
   localparam logic [D2_W-1:0]       DEN2_V    = D2_W'(DEN2);

   logic signed [VPF_CTRL_W-1:0] pt [4];
   logic signed [WGT_W:0]        ws [4];
   logic signed [PRD_W-1:0]      prd_in [4];
   logic signed [PRD_W-1:0]      prd_ff [4];
   logic signed [X_W-1:0]        sum;
   logic signed [X_W-1:0]        x_in, x_ff;
   logic [Z_W-1:0]               z3_in, z3_ff, z4_ff, z5_ff;
   logic                         hi3_in, lo3_in, hi3_ff, lo3_ff, hi4_ff, lo4_ff, hi5_ff, lo5_ff;
   logic [Z_W+M_W-1:0]           p4_in, p4_ff;
   logic [VPF_COORD_W-1:0]       qe_in, qe_ff;
   logic [Z_W-1:0]               qd_in, qd_ff;
   logic [Z_W-1:0]               rem;
   logic [VPF_COORD_W-1:0]       q;

   assign pt[0] = {{(VPF_CTRL_W-VPF_COORD_W){p0[VPF_COORD_W-1]}}, p0};
   assign pt[1] = p1;
   assign pt[2] = p2;
   assign pt[3] = {{(VPF_CTRL_W-VPF_COORD_W){p3[VPF_COORD_W-1]}}, p3};

   for (genvar k = 0; k < 4; k++) begin : g_term
      assign ws[k]     = {1'b0, wgt[k]};
      assign prd_in[k] = pt[k] * ws[k];
   end

   // twice the weighted sum plus the cube: floor of this over twice the cube rounds half up
   assign sum  = X_W'(prd_ff[0]) + X_W'(prd_ff[1]) + X_W'(prd_ff[2]) + X_W'(prd_ff[3]);
   assign x_in = (sum <<< 1) + CUBE_X;

   // clamp out of range, otherwise bias to an unsigned dividend
   assign hi3_in = (x_ff >= OFF_X);
   assign lo3_in = (x_ff < NEG_OFF_X);
   assign z3_in  = Z_W'(x_ff + OFF_X);

   assign p4_in = z3_ff * RECIP_M;

   // reciprocal estimate is the quotient or one below it
   assign qe_in = p4_ff[Z_W+VPF_COORD_W-1:Z_W];
   assign qd_in = qe_in * DEN2_V;

   assign rem = z5_ff - qd_ff;
   assign q   = qe_ff + VPF_COORD_W'(rem >= Z_W'(DEN2_V));

   always_comb begin
      if (hi5_ff) begin
         point = VPF_COORD_MAX;
      end else if (lo5_ff) begin
         point = VPF_COORD_MIN;
      end else begin
         point = {~q[VPF_COORD_W-1], q[VPF_COORD_W-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prd_ff <= prd_in;
         x_ff   <= x_in;
         z3_ff  <= z3_in;
         hi3_ff <= hi3_in;
         lo3_ff <= lo3_in;
         p4_ff  <= p4_in;
         z4_ff  <= z3_ff;
         hi4_ff <= hi3_ff;
         lo4_ff <= lo3_ff;
         qe_ff  <= qe_in;
         qd_ff  <= qd_in;
         z5_ff  <= z4_ff;
         hi5_ff <= hi4_ff;
         lo5_ff <= lo4_ff;
      end
   end

endmodule

// File: sv/vpf_back.sv
module vpf_back
   import vpf_pkg::*;
#(
   parameter int SEGMENTS = VPF_CURVE_SEGMENTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  vpf_job_type q_data,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vpf_rsp_type rsp_data
);

   localparam int WGT_W  = vpf_wgt_width(SEGMENTS);
   localparam int IW     = $clog2(SEGMENTS + 1);
   localparam int STAGES = 5;

   function automatic int weight(int n, int i, int k);
      int u;
      int w;
      u = n - i;
      case (k)
         0:       w = u * u * u;
         1:       w = 3 * u * u * i;
         2:       w = 3 * u * i * i;
         default: w = i * i * i;
      endcase
      return w;
   endfunction

   logic [3:0][WGT_W-1:0] wtab [SEGMENTS+1];

   for (genvar g = 0; g <= SEGMENTS; g++) begin : g_wrow
      for (genvar k = 0; k < 4; k++) begin : g_wcol
         assign wtab[g][k] = WGT_W'(weight(SEGMENTS, g, k));
      end
   end

   vpf_back_state_type state_ff, state_in;
   vpf_job_type        job_ff, job_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   vpf_meta_type       meta_ff [STAGES];
   vpf_meta_type       iss_meta;
   logic               rsp_valid_ff;
   vpf_rsp_type        rsp_data_ff, rsp_data_in;

   logic                          adv;
   logic [IW-1:0]                 idx;
   vpf_point_type                 sel_p0;
   logic signed [VPF_COORD_W-1:0] pt_x, pt_y;

   // whole pipe moves together unless the output word is held
   assign adv = !rsp_valid_ff || !rsp_stall;

   assign idx    = (state_ff == VPF_BK_LEAD) ? '0 : cnt_ff;
   assign sel_p0 = (state_ff == VPF_BK_LEAD) ? job_ff.lead_pt : job_ff.p0;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cnt_in   = cnt_ff;
      pop      = 1'b0;
      iss_meta = '0;
      case (state_ff)
         VPF_BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               job_in   = q_data;
               cnt_in   = (q_data.op == VPF_JOB_CURVE) ? IW'(1) : '0;
               state_in = q_data.lead ? VPF_BK_LEAD : VPF_BK_STEP;
            end
         end
         VPF_BK_LEAD: begin
            if (adv) begin
               iss_meta.valid = 1'b1;
               iss_meta.kind  = VPF_KIND_FIRST;
               iss_meta.last  = 1'b0;
               state_in       = VPF_BK_STEP;
            end
         end
         VPF_BK_STEP: begin
            if (adv) begin
               iss_meta.valid = 1'b1;
               iss_meta.kind  = job_ff.kind;
               iss_meta.last  = (job_ff.op == VPF_JOB_POINT) || (cnt_ff == IW'(SEGMENTS));
               if (iss_meta.last) begin
                  state_in = VPF_BK_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = VPF_BK_IDLE;
         end
      endcase
   end

   vpf_eval #(.SEGMENTS(SEGMENTS)) u_eval_x (
      .clock  (clock),
      .enable (adv),
      .wgt    (wtab[idx]),
      .p0     (sel_p0.x),
      .p1     (job_ff.c1_x),
      .p2     (job_ff.c2_x),
      .p3     (job_ff.p3.x),
      .point  (pt_x)
   );

   vpf_eval #(.SEGMENTS(SEGMENTS)) u_eval_y (
      .clock  (clock),
      .enable (adv),
      .wgt    (wtab[idx]),
      .p0     (sel_p0.y),
      .p1     (job_ff.c1_y),
      .p2     (job_ff.c2_y),
      .p3     (job_ff.p3.y),
      .point  (pt_y)
   );

   assign rsp_data_in.point_x    = pt_x;
   assign rsp_data_in.point_y    = pt_y;
   assign rsp_data_in.point_kind = meta_ff[STAGES-1].kind;
   assign rsp_data_in.last       = meta_ff[STAGES-1].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= VPF_BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < STAGES; s++) begin
            meta_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (adv) begin
            meta_ff[0] <= iss_meta;
            for (int s = 1; s < STAGES; s++) begin
               meta_ff[s] <= meta_ff[s-1];
            end
            rsp_valid_ff <= meta_ff[STAGES-1].valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_lead_from_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == VPF_BK_LEAD && $past(state_ff) != VPF_BK_LEAD)
         |-> $past(state_ff) == VPF_BK_IDLE)
      else $error("lead point issued outside a fresh job");
   a_curve_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == VPF_BK_STEP && job_ff.op == VPF_JOB_CURVE)
         |-> (cnt_ff >= IW'(1) && cnt_ff <= IW'(SEGMENTS)))
      else $error("curve step index out of range");
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.point_kind == VPF_KIND_FIRST) |-> !rsp_data_ff.last)
      else $error("first point of a subpath flagged as last");
`endif

endmodule

// File: sv/vector_path_flattener_core.sv
// Path: the front end queues the job of each accepted command; the back end loads it and
// issues its points through the evaluator's product, sum, bias, reciprocal and quotient
// registers into the output register. Throughput: one point per cycle while the output
// word is not held, after a load per job; a line gives one point, a cubic CURVE_SEGMENTS,
// either one more for a held first point. Move, end and an empty close push no job at all.
// Reset: synchronous, active high; clears path state, queue and pipeline valids.
module vector_path_flattener_core
   import vpf_pkg::*;
#(
   parameter int CURVE_SEGMENTS = VPF_CURVE_SEGMENTS,
   parameter int QUEUE_DEPTH    = VPF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  vpf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vpf_rsp_type rsp_data
);

   // Front end: track the current point, subpath start, last control point
   // and the held first point; turn each command word into at most one job.
   // Back end: walk each job through the Bernstein evaluators, one per coordinate, one
   // point a cycle unless stalled, and hold the result word until the consumer takes it.
   // The job queue between them lets the front end run ahead of a long curve.

   logic        push;
   vpf_job_type push_data;
   logic        q_full;
   logic        q_empty;
   logic        pop;
   vpf_job_type pop_data;

   // Classify and update path state; stall input only when the queue is full.
   vpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   // Decouple the two halves.
   vpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // Sequence points, evaluate with rounding half up and saturation, drive the output word.
   vpf_back #(.SEGMENTS(CURVE_SEGMENTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/tb_vector_path_flattener_core.sv
module tb_vector_path_flattener_core;
   import vpf_pkg::*;

   localparam int SEGMENTS = VPF_CURVE_SEGMENTS;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   vpf_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   vpf_rsp_type rsp_data;

   vector_path_flattener_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Percent of cycles in which each side holds off.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Path state mirrored from the block: pen position, subpath origin,
   // last control point and the held first point of the subpath.
   vpf_point_type pen_pt, sub_start, prev_ctrl, pending_pt;
   bit            pending_ok, sub_drawn;

   vpf_rsp_type cmd_points[$];       // points caused by the command in progress
   vpf_rsp_type expected_points[$];  // points still owed by the block
   vpf_rsp_type want;

   int cmd_count[8];
   int points_checked = 0;
   int mismatches = 0;

   // ------------------------------------------------------------------
   // Point predictor
   // ------------------------------------------------------------------
   function automatic logic signed [VPF_COORD_W-1:0] clamp16(input longint v);
      if (v > 32767) return VPF_COORD_MAX;
      if (v < -32768) return VPF_COORD_MIN;
      return v[VPF_COORD_W-1:0];
   endfunction

   // One coordinate of a curve sample: Bernstein sum over segments cubed,
   // rounded half toward +infinity, then saturated.
   function automatic logic signed [VPF_COORD_W-1:0] curve_coord(
      input longint p0, input longint p1, input longint p2, input longint p3,
      input int step);
      longint n, u, num2, den2, q;
      n    = SEGMENTS;
      u    = n - step;
      num2 = 2 * (u * u * u * p0 + 3 * u * u * step * p1 + 3 * u * step * step * p2
                  + longint'(step) * step * step * p3) + n * n * n;
      den2 = 2 * n * n * n;
      q    = num2 / den2;
      // integer divide truncates; turn that into a floor for negatives
      if (num2 % den2 != 0 && num2 < 0) q = q - 1;
      return clamp16(q);
   endfunction

   function automatic vpf_rsp_type make_point(input logic signed [VPF_COORD_W-1:0] x,
                                              input logic signed [VPF_COORD_W-1:0] y,
                                              input logic [1:0] kind);
      return '{point_x: x, point_y: y, point_kind: kind, last: 1'b0};
   endfunction

   function automatic void reset_pen_state();
      pen_pt     = '0;
      sub_start  = '0;
      prev_ctrl  = '0;
      pending_pt = '0;
      pending_ok = 1'b0;
      sub_drawn  = 1'b0;
   endfunction

   // Drawing with no open subpath starts one at the pen position.
   function automatic void open_subpath();
      if (!pending_ok && !sub_drawn) begin
         pending_pt = pen_pt;
         sub_start  = pen_pt;
         pending_ok = 1'b1;
      end
   endfunction

   // Release the held first point ahead of the first drawn point.
   function automatic void add_draw_point(input logic signed [VPF_COORD_W-1:0] x,
                                          input logic signed [VPF_COORD_W-1:0] y);
      if (!sub_drawn && pending_ok) begin
         cmd_points = {cmd_points, make_point(pending_pt.x, pending_pt.y, VPF_KIND_FIRST)};
         pending_ok = 1'b0;
         sub_drawn  = 1'b1;
      end
      cmd_points = {cmd_points, make_point(x, y, VPF_KIND_NEXT)};
   endfunction

   function automatic void predict_points(input vpf_req_type w);
      int                            bx, by, c1x, c1y, c2x, c2y;
      logic signed [VPF_COORD_W-1:0] tx, ty;
      vpf_cmd_type                   op;
      op  = vpf_cmd_type'(w.command);
      bx  = w.relative ? int'(pen_pt.x) : 0;
      by  = w.relative ? int'(pen_pt.y) : 0;
      // control points stay exact, wider than a coordinate
      c1x = int'(w.ctrl1_x) + bx;
      c1y = int'(w.ctrl1_y) + by;
      c2x = int'(w.ctrl2_x) + bx;
      c2y = int'(w.ctrl2_y) + by;
      tx  = clamp16(longint'(w.end_x) + bx);
      ty  = clamp16(longint'(w.end_y) + by);
      cmd_points.delete();
      cmd_count[w.command]++;
      case (op)
         VPF_CMD_MOVE: begin
            // drop any held point that never got drawn
            pen_pt     = '{x: tx, y: ty};
            sub_start  = pen_pt;
            pending_pt = pen_pt;
            pending_ok = 1'b1;
            sub_drawn  = 1'b0;
            prev_ctrl  = pen_pt;
         end
         VPF_CMD_LINE, VPF_CMD_HORIZ, VPF_CMD_VERT: begin
            open_subpath();
            if (op == VPF_CMD_HORIZ) ty = pen_pt.y;
            if (op == VPF_CMD_VERT) tx = pen_pt.x;
            add_draw_point(tx, ty);
            pen_pt    = '{x: tx, y: ty};
            prev_ctrl = pen_pt;
         end
         VPF_CMD_CUBIC, VPF_CMD_SMOOTH: begin
            open_subpath();
            // smooth: mirror the previous control point through the pen
            if (op == VPF_CMD_SMOOTH) begin
               c1x = 2 * int'(pen_pt.x) - int'(prev_ctrl.x);
               c1y = 2 * int'(pen_pt.y) - int'(prev_ctrl.y);
            end
            for (int i = 1; i <= SEGMENTS; i++)
               add_draw_point(curve_coord(pen_pt.x, c1x, c2x, tx, i),
                              curve_coord(pen_pt.y, c1y, c2y, ty, i));
            prev_ctrl = '{x: clamp16(c2x), y: clamp16(c2y)};
            pen_pt    = '{x: tx, y: ty};
         end
         VPF_CMD_CLOSE: begin
            // only a subpath that drew something gets a close marker
            if (sub_drawn)
               cmd_points = {cmd_points,
                             make_point(sub_start.x, sub_start.y, VPF_KIND_CLOSE)};
            pending_ok = 1'b0;
            sub_drawn  = 1'b0;
            pen_pt     = sub_start;
            prev_ctrl  = sub_start;
         end
         default: reset_pen_state();
      endcase
      if (cmd_points.size() > 0) cmd_points[cmd_points.size() - 1].last = 1'b1;
      foreach (cmd_points[k]) expected_points = {expected_points, cmd_points[k]};
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic vpf_req_type item(input vpf_cmd_type cmd, input bit rel,
                                        input int ex, input int ey,
                                        input int c1x, input int c1y,
                                        input int c2x, input int c2y);
      vpf_req_type w;
      w.command  = cmd;
      w.relative = rel;
      w.end_x    = ex[VPF_COORD_W-1:0];
      w.end_y    = ey[VPF_COORD_W-1:0];
      w.ctrl1_x  = c1x[VPF_COORD_W-1:0];
      w.ctrl1_y  = c1y[VPF_COORD_W-1:0];
      w.ctrl2_x  = c2x[VPF_COORD_W-1:0];
      w.ctrl2_y  = c2y[VPF_COORD_W-1:0];
      return w;
   endfunction

   // Mostly near the origin so paths stay in range, some full-range values
   // and a few extremes to hit saturation.
   function automatic int rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return int'($urandom_range(0, 4095)) - 2048;
      if (pick < 9) return int'($urandom());
      case ($urandom_range(0, 3))
         0:       return int'(VPF_COORD_MAX);
         1:       return int'(VPF_COORD_MIN);
         2:       return 0;
         default: return -1;
      endcase
   endfunction

   function automatic vpf_req_type random_word(input vpf_cmd_type cmd);
      return item(cmd, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endfunction

   function automatic vpf_cmd_type random_draw_cmd();
      return vpf_cmd_type'($urandom_range(int'(VPF_CMD_LINE), int'(VPF_CMD_SMOOTH)));
   endfunction

   // Offer one word and hold it until the block takes it.
   task automatic send_word(input vpf_req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predict_points(w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold until every owed point has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall, then compare every accepted word in order
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic void note_mismatch(input string what, input vpf_rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $write("mismatch (%s): expected x=%0d y=%0d kind=%0d last=%0d, ",
                what, want.point_x, want.point_y, want.point_kind, want.last);
         $display("got x=%0d y=%0d kind=%0d last=%0d",
                  got.point_x, got.point_y, got.point_kind, got.last);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            want = '0;
            note_mismatch("no point owed", rsp_data);
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (rsp_data.point_x !== want.point_x || rsp_data.point_y !== want.point_y ||
                rsp_data.point_kind !== want.point_kind || rsp_data.last !== want.last)
               note_mismatch("field", rsp_data);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // draw straight out of reset: origin becomes the held first point
      send_word(item(VPF_CMD_LINE,   0, 'h0100, 'h0200, 'h7FFF, 'h8000, -1, 0));
      send_word(item(VPF_CMD_HORIZ,  1, 'h0080, 'h7FFF, 0, 0, 0, 0));
      send_word(item(VPF_CMD_VERT,   0, 'h1234, -'h0300, 0, 0, 0, 0));
      // extreme control points must not wrap
      send_word(item(VPF_CMD_CUBIC,  0, 'h0400, 'h0400, 'h7FFF, 'h8000, 'h8000, 'h7FFF));
      // smooth after a curve: reflect the previous control point
      send_word(item(VPF_CMD_SMOOTH, 1, 'h0100, -'h0100, 'h5555, 'h2AAA, 'h0200, 0));
      // close with points drawn, then an empty close
      send_word(item(VPF_CMD_CLOSE,  1, 'h7FFF, 'h7FFF, -1, -1, -1, -1));
      send_word(item(VPF_CMD_CLOSE,  0, 0, 0, 0, 0, 0, 0));
      // drawing after a close reopens at the subpath start
      send_word(item(VPF_CMD_LINE,   1, 'h0040, 'h0040, 0, 0, 0, 0));
      // smooth after a line: first control is the pen
      send_word(item(VPF_CMD_SMOOTH, 0, -'h0200, 'h0300, 'h7FFF, 'h7FFF, 'h0100, 'h0100));
      // relative draws that push past the coordinate range saturate
      send_word(item(VPF_CMD_MOVE,   0, 'h7F00, -'h7F00, 0, 0, 0, 0));
      send_word(item(VPF_CMD_LINE,   1, 'h7FFF, 'h8000, 0, 0, 0, 0));
      send_word(item(VPF_CMD_CUBIC,  1, 'h7FFF, 'h8000, 'h7FFF, 'h7FFF, 'h8000, 'h8000));
      send_word(item(VPF_CMD_SMOOTH, 1, 'h8000, 'h7FFF, 0, 0, 'h7FFF, 'h8000));
      // back-to-back moves drop the first held point
      send_word(item(VPF_CMD_MOVE,   0, 'h0100, 'h0100, 0, 0, 0, 0));
      send_word(item(VPF_CMD_MOVE,   0, 'h0200, 'h0200, 0, 0, 0, 0));
      send_word(item(VPF_CMD_LINE,   0, 'h0300, 'h0300, 0, 0, 0, 0));
      // close of a subpath that only moved gives nothing
      send_word(item(VPF_CMD_MOVE,   0, 'h1000, 'h1000, 0, 0, 0, 0));
      send_word(item(VPF_CMD_CLOSE,  1, 0, 0, 0, 0, 0, 0));
      send_word(item(VPF_CMD_CUBIC,  0, 0, 0, 0, 0, 0, 0));
      send_word(item(VPF_CMD_END,    1, 'h7FFF, 'h8000, 'h7FFF, 'h8000, 'h7FFF, 'h8000));
      // a lone move followed by end of path emits nothing
      send_word(item(VPF_CMD_MOVE,   0, -1, -1, 0, 0, 0, 0));
      send_word(item(VPF_CMD_END,    0, 0, 0, 0, 0, 0, 0));
      // draw with no move after end: starts at the origin again
      send_word(item(VPF_CMD_VERT,   1, 'h5A5A, -'h0001, 0, 0, 0, 0));
      send_word(item(VPF_CMD_CUBIC,  1, 'h8000, 'h8000, 'h8000, 'h8000, 'h8000, 'h8000));
      send_word(item(VPF_CMD_END,    0, 0, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   // Mostly well-formed subpaths with random content; the rest is noise.
   task automatic run_paths(input int count);
      int sent, draws;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 10) begin
            send_word(random_word(vpf_cmd_type'($urandom_range(int'(VPF_CMD_MOVE),
                                                               int'(VPF_CMD_END)))));
            sent++;
         end else begin
            send_word(random_word(VPF_CMD_MOVE));
            sent++;
            draws = $urandom_range(1, 6);
            repeat (draws) begin
               send_word(random_word(random_draw_cmd()));
               sent++;
            end
            if ($urandom_range(0, 99) < 45) begin
               send_word(random_word(VPF_CMD_CLOSE));
               sent++;
               // keep drawing from the closed subpath's start
               if ($urandom_range(0, 99) < 30) begin
                  send_word(random_word(random_draw_cmd()));
                  sent++;
               end
            end
            if ($urandom_range(0, 99) < 25) begin
               send_word(random_word(VPF_CMD_END));
               sent++;
            end
         end
      end
      wait_drained();
   endtask

   task automatic test_paths_slow_receiver();
      send_idle_pct = 14;
      recv_idle_pct = 81;
      run_paths(130);
   endtask

   task automatic test_paths_slow_sender();
      send_idle_pct = 81;
      recv_idle_pct = 14;
      run_paths(130);
   endtask

   task automatic test_paths_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_paths(140);
   endtask

   // Let the block run completely dry in the middle of a subpath.
   task automatic test_drain_pause();
      send_word(random_word(VPF_CMD_MOVE));
      send_word(random_word(VPF_CMD_CUBIC));
      wait_drained();
      send_word(random_word(VPF_CMD_SMOOTH));
      send_word(random_word(VPF_CMD_LINE));
      wait_drained();
      send_word(random_word(VPF_CMD_CLOSE));
      wait_drained();
   endtask

   initial begin
      reset_pen_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_paths_slow_receiver();
      test_drain_pause();
      test_paths_slow_sender();
      test_paths_full_rate();

      wait_drained();
      // allow for stray words past the pipeline latency
      repeat (20) @(posedge clock);

      $display("covered %0d moves, %0d lines, %0d horizontals, %0d verticals, %0d cubics,",
               cmd_count[VPF_CMD_MOVE], cmd_count[VPF_CMD_LINE], cmd_count[VPF_CMD_HORIZ],
               cmd_count[VPF_CMD_VERT], cmd_count[VPF_CMD_CUBIC]);
      $display("%0d smooth cubics, %0d closes, %0d path ends; %0d points checked, %0d mismatches",
               cmd_count[VPF_CMD_SMOOTH], cmd_count[VPF_CMD_CLOSE], cmd_count[VPF_CMD_END],
               points_checked, mismatches);
      if (mismatches == 0 && expected_points.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d points still owed", expected_points.size());
      $display("status: fail");
      $finish;
   end

endmodule
